// ----- sv/pipq_pkg.sv -----
// Shared types and codes for the point-in-polygon quadrant winding block.
// Used by pipq_ctrl, pipq_dp and point_in_polygon_quadrant_unit; depends on nothing.
package pipq_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    // request commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_CLOSE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic issue;     // read the vertex at the walk address
        logic head;      // first vertex is on the read port
        logic walk;      // edge from current vertex to read vertex
        logic close;     // closing edge back to the first vertex
        logic load_out;  // load the result register
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic query_go;  // query request on a non-empty polygon
        logic more;      // vertices left to read
    } dp_stat_t;

    // quadrant of a vertex around the query point, coded 1 to 4
    function automatic logic [2:0] quad_code(input logic right, input logic above);
        logic [2:0] q;
        if (right)
            q = above ? 3'd1 : 3'd4;
        else
            q = above ? 3'd2 : 3'd3;
        return q;
    endfunction

endpackage

// ----- sv/pipq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the polygon vertices; depends on nothing.
module pipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pipq_ctrl.sv -----
// Sequencer for the point-in-polygon block: request handshake, vertex walk, result handshake.
// Depends on pipq_pkg for the state type and the command and status structs.
module pipq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  pipq_pkg::dp_stat_t  stat,
    output pipq_pkg::ctl_cmd_t  cmd
);

    pipq_pkg::state_t state_reg;
    pipq_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // result register can take a new result
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pipq_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = stat.query_go ? pipq_pkg::ST_HEAD : pipq_pkg::ST_DONE;
            end
            pipq_pkg::ST_HEAD,
            pipq_pkg::ST_WALK:
            begin
                state_next = stat.more ? pipq_pkg::ST_WALK : pipq_pkg::ST_CLOSE;
            end
            pipq_pkg::ST_CLOSE:  state_next = pipq_pkg::ST_DRAIN1;
            pipq_pkg::ST_DRAIN1: state_next = pipq_pkg::ST_DRAIN2;
            pipq_pkg::ST_DRAIN2: state_next = pipq_pkg::ST_DONE;
            pipq_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = pipq_pkg::ST_IDLE;
            end
            default: state_next = pipq_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_stall     = (state_reg != pipq_pkg::ST_IDLE);
        cmd.accept   = (state_reg == pipq_pkg::ST_IDLE) && in_valid;
        cmd.issue    = (cmd.accept && stat.query_go)
                     || (((state_reg == pipq_pkg::ST_HEAD) || (state_reg == pipq_pkg::ST_WALK))
                         && stat.more);
        cmd.head     = (state_reg == pipq_pkg::ST_HEAD);
        cmd.walk     = (state_reg == pipq_pkg::ST_WALK);
        cmd.close    = (state_reg == pipq_pkg::ST_CLOSE);
        cmd.load_out = (state_reg == pipq_pkg::ST_DONE) && out_free;
    end

    // result valid flag
    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pipq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a taken request always moves the sequencer out of idle in the cycle after
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> in_stall)
        else $error("request taken but sequencer stayed idle");

endmodule

// ----- sv/pipq_dp.sv -----
// Datapath for the point-in-polygon block: vertex store, count, edge pipeline, result register.
// Depends on pipq_pkg and pipq_ram.
module pipq_dp #(
    parameter int MAX_VERTICES = pipq_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipq_pkg::COORD_BITS_DEF,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pipq_pkg::ctl_cmd_t           cmd,
    output pipq_pkg::dp_stat_t           stat,
    input  logic [1:0]                   command,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         inside_res,
    output logic [1:0]                   status,
    output logic [CNT_W-1:0]             stored_vertices
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int DW    = COORD_BITS + 1;     // coordinate difference
    localparam int PW    = 2 * DW;             // product
    localparam int SW    = PW + 1;             // product difference
    localparam int ACC_W = CNT_W + 2;          // winding sum, at most 2 per edge
    localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(4);

    // vertex count and walk address
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             full;

    // request capture
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [1:0]                   res_status_reg;

    // vertex store
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic [2*COORD_BITS-1:0]   rd_data;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;

    // walk state
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic [2:0]                   q_reg;

    // stage 1: quadrant step and differences
    logic signed [COORD_BITS-1:0] nxt_x;
    logic signed [COORD_BITS-1:0] nxt_y;
    logic [2:0]                   nq;
    logic signed [3:0]            d_raw;
    logic signed [3:0]            d_adj;
    logic                         s1_valid_reg;
    logic signed [3:0]            s1_delta_reg;
    logic                         s1_is2_reg;
    logic signed [DW-1:0]         s1_a_reg;
    logic signed [DW-1:0]         s1_b_reg;
    logic signed [DW-1:0]         s1_c_reg;
    logic signed [DW-1:0]         s1_d_reg;

    // stage 2: products
    logic                         s2_valid_reg;
    logic signed [3:0]            s2_delta_reg;
    logic                         s2_is2_reg;
    logic                         s2_dy_pos_reg;
    logic                         s2_dy_neg_reg;
    logic signed [PW-1:0]         s2_pab_reg;
    logic signed [PW-1:0]         s2_pcd_reg;

    // stage 3: intercept side and sum
    logic signed [SW-1:0]         pdiff;
    logic                         right;
    logic signed [3:0]            fdelta;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_next;

    // result register
    logic                         inside_out_reg;
    logic [1:0]                   status_out_reg;
    logic [CNT_W-1:0]             count_out_reg;

    assign full = (cnt_reg == CNT_W'(MAX_VERTICES));

    // status to the controller
    always_comb
    begin
        stat.query_go = (command == pipq_pkg::CMD_QUERY) && (cnt_reg != '0);
        stat.more     = (idx_reg != cnt_reg);
    end

    // count update on a request
    always_comb
    begin
        cnt_next = cnt_reg;
        wr_en    = 1'b0;
        if (cmd.accept)
        begin
            unique case (command)
                pipq_pkg::CMD_CLEAR:  cnt_next = '0;
                pipq_pkg::CMD_APPEND:
                begin
                    if (!full)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        wr_en    = 1'b1;
                    end
                end
                default: cnt_next = cnt_reg;
            endcase
        end
    end

    // walk address: vertex 0 is read on the request cycle
    assign rd_addr = cmd.accept ? '0 : idx_reg[AW-1:0];

    always_comb
    begin
        priority if (cmd.accept)
            idx_next = CNT_W'(1);
        else if (cmd.issue)
            idx_next = idx_reg + CNT_W'(1);
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // request payload and its status
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            unique case (command)
                pipq_pkg::CMD_APPEND:
                    res_status_reg <= full ? pipq_pkg::STAT_FULL : pipq_pkg::STAT_OK;
                pipq_pkg::CMD_QUERY:
                    res_status_reg <= (cnt_reg == '0) ? pipq_pkg::STAT_EMPTY
                                                      : pipq_pkg::STAT_OK;
                default:
                    res_status_reg <= pipq_pkg::STAT_OK;
            endcase
        end
    end

    // vertex store, x in the upper half
    pipq_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({coord_x, coord_y}),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_x = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
    assign rd_y = $signed(rd_data[COORD_BITS-1:0]);

    // next vertex of the edge and its quadrant step
    always_comb
    begin
        nxt_x = cmd.close ? first_x_reg : rd_x;
        nxt_y = cmd.close ? first_y_reg : rd_y;
        nq    = pipq_pkg::quad_code(nxt_x > px_reg, nxt_y > py_reg);
        d_raw = $signed({1'b0, nq}) - $signed({1'b0, q_reg});
        priority if (d_raw == 4'sd3)
            d_adj = -4'sd1;
        else if (d_raw == -4'sd3)
            d_adj = 4'sd1;
        else
            d_adj = d_raw;
    end

    // first and current vertex of the walk
    always_ff @(posedge clk)
    begin
        if (cmd.head)
        begin
            first_x_reg <= rd_x;
            first_y_reg <= rd_y;
            cur_x_reg   <= rd_x;
            cur_y_reg   <= rd_y;
            q_reg       <= pipq_pkg::quad_code(rd_x > px_reg, rd_y > py_reg);
        end
        else if (cmd.walk || cmd.close)
        begin
            cur_x_reg <= nxt_x;
            cur_y_reg <= nxt_y;
            q_reg     <= nq;
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.walk || cmd.close;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        s1_delta_reg <= d_adj;
        s1_is2_reg   <= (d_adj == 4'sd2) || (d_adj == -4'sd2);
        s1_a_reg     <= DW'(nxt_x) - DW'(px_reg);
        s1_b_reg     <= DW'(cur_y_reg) - DW'(nxt_y);
        s1_c_reg     <= DW'(nxt_y) - DW'(py_reg);
        s1_d_reg     <= DW'(cur_x_reg) - DW'(nxt_x);
    end

    // stage 2: cross products of the intercept test
    always_ff @(posedge clk)
    begin
        s2_delta_reg  <= s1_delta_reg;
        s2_is2_reg    <= s1_is2_reg;
        s2_dy_pos_reg <= !s1_b_reg[DW-1] && (s1_b_reg != '0);
        s2_dy_neg_reg <= s1_b_reg[DW-1];
        s2_pab_reg    <= PW'(s1_a_reg) * PW'(s1_b_reg);
        s2_pcd_reg    <= PW'(s1_c_reg) * PW'(s1_d_reg);
    end

    // stage 3: flip a half turn whose crossing lies right of the point
    always_comb
    begin
        pdiff  = SW'(s2_pab_reg) - SW'(s2_pcd_reg);
        right  = (s2_dy_pos_reg && !pdiff[SW-1] && (pdiff != '0))
              || (s2_dy_neg_reg && pdiff[SW-1]);
        fdelta = (s2_is2_reg && right) ? -s2_delta_reg : s2_delta_reg;
        priority if (cmd.accept)
            acc_next = '0;
        else if (s2_valid_reg)
            acc_next = acc_reg + ACC_W'(fdelta);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            inside_out_reg <= (acc_reg == FULL_TURN) || (acc_reg == -FULL_TURN);
            status_out_reg <= res_status_reg;
            count_out_reg  <= cnt_reg;
        end
    end

    assign inside_res      = inside_out_reg;
    assign status          = status_out_reg;
    assign stored_vertices = count_out_reg;

    // count never passes the store depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // closing edge only after every vertex has been read
    a_close_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> !stat.more)
        else $error("closing edge with vertices still unread");

    // result is loaded only once the edge pipeline is empty
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("result loaded with edges in flight");

endmodule

// ----- sv/point_in_polygon_quadrant_unit.sv -----
// Point-in-polygon block using the quadrant winding test.
// Top level; depends on pipq_pkg, pipq_ctrl, pipq_dp and pipq_ram.
//
// The block keeps one polygon of up to MAX_VERTICES vertices and answers one
// request at a time: clear the polygon, append a vertex, or test whether a
// point lies inside. Every request gives exactly one result with the inside
// flag, a status (ok, vertex dropped because the store is full, query on an
// empty polygon) and the vertex count after the request. Clear, append and
// unused commands go from the request straight to the result register; a query
// walks the vertices through the vertex store's single read port, which feeds
// the three-stage edge pipeline one vertex per cycle, and loads its result once
// the pipeline has drained. A new request is taken as soon as the previous result
// has been loaded into the result register, even while that result still waits.
module point_in_polygon_quadrant_unit #(
    parameter int MAX_VERTICES = pipq_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipq_pkg::COORD_BITS_DEF,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         inside_res,
    output logic [1:0]                   status,
    output logic [CNT_W-1:0]             stored_vertices
);

    pipq_pkg::ctl_cmd_t cmd;
    pipq_pkg::dp_stat_t stat;

    // sequencer
    pipq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store, edge pipeline and result register
    pipq_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .inside_res      (inside_res),
        .status          (status),
        .stored_vertices (stored_vertices)
    );

endmodule

// ----- sim/tb_point_in_polygon_quadrant_unit.sv -----
// Testbench for point_in_polygon_quadrant_unit: random and directed requests against
// a built-in predictor of the quadrant winding test. Depends on pipq_pkg and the RTL.
module tb_point_in_polygon_quadrant_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POLY_DEPTH   = pipq_pkg::MAX_VERTICES_DEF;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } request_t;

    typedef struct {
        logic       in_poly;
        logic [1:0] status;
        logic [6:0] count;
    } verdict_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = pipq_pkg::CMD_CLEAR;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               inside_res;
    logic [1:0]         status;
    logic [6:0]         stored_vertices;

    request_t request_queue [$];
    verdict_t verdict_queue [$];
    int       mismatch_count = 0;
    int       accepted_total = 0;
    int       idle_cycles = 0;

    // predictor copy of the polygon store
    logic signed [15:0] poly_x [POLY_DEPTH];
    logic signed [15:0] poly_y [POLY_DEPTH];
    int unsigned        poly_count = 0;

    // no idling on either side through this stretch of requests
    wire calm = (accepted_total >= 250) && (accepted_total < 400);

    point_in_polygon_quadrant_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .inside_res      (inside_res),
        .status          (status),
        .stored_vertices (stored_vertices)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // quadrant of a vertex around the query point
    function automatic int quad_of(longint vx, longint vy, longint px, longint py);
        if (vx > px)
            return (vy > py) ? 1 : 4;
        return (vy > py) ? 2 : 3;
    endfunction

    // exact test whether the edge crosses y = py right of px
    function automatic bit crosses_right(longint x1, longint y1, longint x2, longint y2,
                                         longint px, longint py);
        longint dy, lhs, rhs;
        dy  = y1 - y2;
        lhs = (x2 - px) * dy;
        rhs = (y2 - py) * (x1 - x2);
        if (dy > 0)
            return lhs > rhs;
        if (dy < 0)
            return lhs < rhs;
        return 1'b0;
    endfunction

    // sum of quadrant steps around the closed polygon
    function automatic bit winding_inside(longint px, longint py);
        int          total, q, nq, delta;
        int unsigned nx;
        total = 0;
        q = quad_of(poly_x[0], poly_y[0], px, py);
        for (int unsigned e = 0; e < poly_count; e++)
        begin
            nx = (e + 1 < poly_count) ? e + 1 : 0;
            nq = quad_of(poly_x[nx], poly_y[nx], px, py);
            delta = nq - q;
            if (delta == 3)
                delta = -1;
            else if (delta == -3)
                delta = 1;
            else if ((delta == 2 || delta == -2) &&
                     crosses_right(poly_x[e], poly_y[e], poly_x[nx], poly_y[nx], px, py))
                delta = -delta;
            total += delta;
            q = nq;
        end
        return (total == 4) || (total == -4);
    endfunction

    // apply one request to the predicted store and return its result
    function automatic verdict_t apply_request(request_t req);
        verdict_t v;
        v.in_poly = 1'b0;
        v.status  = pipq_pkg::STAT_OK;
        unique case (req.cmd)
            pipq_pkg::CMD_CLEAR:
                poly_count = 0;
            pipq_pkg::CMD_APPEND:
                if (poly_count < POLY_DEPTH)
                begin
                    poly_x[poly_count] = req.x;
                    poly_y[poly_count] = req.y;
                    poly_count++;
                end
                else
                    v.status = pipq_pkg::STAT_FULL;
            pipq_pkg::CMD_QUERY:
                if (poly_count == 0)
                    v.status = pipq_pkg::STAT_EMPTY;
                else
                    v.in_poly = winding_inside(req.x, req.y);
            default:
                ;
        endcase
        v.count = poly_count[6:0];
        return v;
    endfunction

    task automatic add_request(logic [1:0] cmd, logic [15:0] x, logic [15:0] y);
        request_t req;
        req.cmd = cmd;
        req.x   = x;
        req.y   = y;
        request_queue = {request_queue, req};
    endtask

    // full-range coordinate for span 0, else within +-span
    function automatic logic [15:0] pick_coord(int span);
        int v;
        if (span == 0)
            return 16'($urandom);
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    // request driver: predicts each request as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        verdict_t pred;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= pipq_pkg::CMD_CLEAR;
            coord_x  <= '0;
            coord_y  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                req.cmd = command;
                req.x   = coord_x;
                req.y   = coord_y;
                pred    = apply_request(req);
                verdict_queue = {verdict_queue, pred};
                accepted_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (request_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 10))
                begin
                    req = request_queue.pop_front();
                    in_valid <= 1'b1;
                    command  <= req.cmd;
                    coord_x  <= req.x;
                    coord_y  <= req.y;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: result with no request pending: inside=%0d status=%0d count=%0d",
                             $realtime, inside_res, status, stored_vertices);
                    mismatch_count++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (inside_res !== want.in_poly)
                    begin
                        $display("%0t: inside_res expected %0d actual %0d",
                                 $realtime, want.in_poly, inside_res);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, status);
                        mismatch_count++;
                    end
                    if (stored_vertices !== want.count)
                    begin
                        $display("%0t: stored_vertices expected %0d actual %0d",
                                 $realtime, want.count, stored_vertices);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus: directed requests, a full drain, then random polygon sessions
    initial
    begin
        int          produced, span, n_vert, n_query, roll;
        logic [15:0] qx, qy;
        logic [15:0] shape_x [$];
        logic [15:0] shape_y [$];

        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // query on an empty polygon, unused command with all bits set
        add_request(pipq_pkg::CMD_QUERY, 16'sd0, 16'sd0);
        add_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        // square at the coordinate extremes
        add_request(pipq_pkg::CMD_APPEND, 16'h8000, 16'h8000);
        add_request(pipq_pkg::CMD_APPEND, 16'h7FFF, 16'h8000);
        add_request(pipq_pkg::CMD_APPEND, 16'h7FFF, 16'h7FFF);
        add_request(pipq_pkg::CMD_APPEND, 16'h8000, 16'h7FFF);
        add_request(pipq_pkg::CMD_QUERY, 16'sd0, 16'sd0);
        add_request(pipq_pkg::CMD_QUERY, 16'h8000, 16'sd0);
        add_request(pipq_pkg::CMD_QUERY, 16'h7FFF, 16'h7FFF);
        add_request(pipq_pkg::CMD_QUERY, 16'sd0, 16'h8000);
        // degenerate polygons of one and two vertices
        add_request(pipq_pkg::CMD_CLEAR, 16'h7FFF, 16'h8000);
        add_request(pipq_pkg::CMD_APPEND, 16'sd5, 16'sd5);
        add_request(pipq_pkg::CMD_QUERY, 16'sd0, 16'sd0);
        add_request(pipq_pkg::CMD_QUERY, 16'sd5, 16'sd5);
        add_request(pipq_pkg::CMD_APPEND, -16'sd5, 16'sd10);
        add_request(pipq_pkg::CMD_QUERY, 16'sd0, 16'sd7);
        // small triangle with points inside, outside and on the slanted edge
        add_request(pipq_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
        add_request(pipq_pkg::CMD_APPEND, 16'sd0, 16'sd0);
        add_request(pipq_pkg::CMD_APPEND, 16'sd10, 16'sd0);
        add_request(pipq_pkg::CMD_APPEND, 16'sd0, 16'sd10);
        add_request(pipq_pkg::CMD_QUERY, 16'sd2, 16'sd2);
        add_request(pipq_pkg::CMD_QUERY, 16'sd10, 16'sd10);
        add_request(pipq_pkg::CMD_QUERY, 16'sd5, 16'sd5);
        add_request(CMD_UNUSED, 16'sd0, 16'sd0);
        add_request(pipq_pkg::CMD_QUERY, -16'sd1, 16'sd3);

        // hold off until every result is back
        while (request_queue.size() > 0 || in_valid || verdict_queue.size() > 0)
            @(negedge clk);

        produced = 0;
        while (produced < 650)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // noise request of any command
                add_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                produced++;
            end
            else
            begin
                roll = $urandom_range(0, 3);
                span = (roll == 0) ? 0 : ((roll == 1) ? 20 : 2000);
                if ($urandom_range(0, 9) != 0)
                begin
                    add_request(pipq_pkg::CMD_CLEAR, pick_coord(0), pick_coord(0));
                    shape_x.delete();
                    shape_y.delete();
                    produced++;
                end
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    n_vert = $urandom_range(60, 70);
                else if (roll < 12)
                    n_vert = $urandom_range(0, 2);
                else
                    n_vert = $urandom_range(3, 12);
                for (int i = 0; i < n_vert; i++)
                begin
                    qx = pick_coord(span);
                    qy = pick_coord(span);
                    add_request(pipq_pkg::CMD_APPEND, qx, qy);
                    shape_x = {shape_x, qx};
                    shape_y = {shape_y, qy};
                end
                produced += n_vert;
                n_query = $urandom_range(1, 6);
                for (int i = 0; i < n_query; i++)
                begin
                    // query points often reuse vertex coordinates to hit the ties
                    if (shape_x.size() > 0 && $urandom_range(0, 99) < 35)
                        qx = shape_x[$urandom_range(0, shape_x.size() - 1)];
                    else
                        qx = pick_coord(span);
                    if (shape_y.size() > 0 && $urandom_range(0, 99) < 35)
                        qy = shape_y[$urandom_range(0, shape_y.size() - 1)];
                    else
                        qy = pick_coord(span);
                    add_request(pipq_pkg::CMD_QUERY, qx, qy);
                end
                produced += n_query;
            end
        end

        // drain, then let the block settle
        while (request_queue.size() > 0 || in_valid || verdict_queue.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
